// ----- hw/rtl/prt_pkg.sv -----
// Shared types and constants for the progress report timer.
`timescale 1ns / 1ps
package prt_pkg;

  localparam int TimeWidth    = 32;
  localparam int FieldWidth   = 32;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 32;

  localparam logic [CfgIdxWidth-1:0] CFG_DELAY_MS        = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DELAY_ENABLE    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_INTERVAL_MS     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_INTERVAL_ENABLE = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_OFFSET_MS       = 3'd4;

  typedef enum logic [2:0] {
    OP_ARM    = 3'd0,
    OP_START  = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_STOP   = 3'd4,
    OP_SAMPLE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ARMED   = 2'd1,
    MODE_RUNNING = 2'd2,
    MODE_PAUSED  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0]            op;
    logic [FieldWidth-1:0] position_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            mode_now;
    logic                  accepted;
    logic                  delay_elapsed;
    logic                  interval_elapsed;
    logic [FieldWidth-1:0] next_target_ms;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- hw/rtl/prt_div.sv -----
// Restoring divider that yields the remainder, one bit per cycle.
`timescale 1ns / 1ps
module prt_div #(
  parameter int TIME_WIDTH = prt_pkg::TimeWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TIME_WIDTH-1:0] dividend_i,
  input  logic [TIME_WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic [TIME_WIDTH-1:0] rem_o
);

  localparam int CntWidth = $clog2(TIME_WIDTH);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] dvd_q, dvd_d;
  logic [TIME_WIDTH-1:0] dsr_q, dsr_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [TIME_WIDTH:0]   part;

  assign part = {rem_q, dvd_q[TIME_WIDTH-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(TIME_WIDTH - 1);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (part >= {1'b0, dsr_q}) begin
        rem_d = TIME_WIDTH'(part - {1'b0, dsr_q});
      end else begin
        rem_d = TIME_WIDTH'(part);
      end
      dvd_d = {dvd_q[TIME_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q != '0) |=> busy_q) else $error("divider stopped early");

endmodule

// ----- hw/rtl/prt_datapath.sv -----
// Datapath: configuration, timer state, target arithmetic and result register.
`timescale 1ns / 1ps
module prt_datapath #(
  parameter int TIME_WIDTH = prt_pkg::TimeWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prt_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [prt_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  input  prt_pkg::in_item_t                 in_item_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output prt_pkg::out_item_t                out_item_o,
  input  prt_pkg::ctrl_cmd_t                cmd_i,
  output prt_pkg::dp_status_t               status_o
);

  localparam logic [TIME_WIDTH-1:0] TimeMax = '1;

  logic [TIME_WIDTH-1:0] cfg_delay_q, cfg_interval_q, cfg_offset_q;
  logic                  cfg_delay_en_q, cfg_interval_en_q;

  prt_pkg::mode_e        mode_q, mode_d;
  logic                  dly_act_q, dly_act_d;
  logic                  int_act_q, int_act_d;
  logic [TIME_WIDTH-1:0] delay_q, delay_d;
  logic [TIME_WIDTH-1:0] iv_q, iv_d;
  logic [TIME_WIDTH-1:0] offset_q, offset_d;
  logic [TIME_WIDTH-1:0] target_q, target_d;

  logic [2:0]            op_q;
  logic [TIME_WIDTH-1:0] pos_q;

  logic                  out_valid_q;
  prt_pkg::out_item_t    out_q, out_d;

  logic [TIME_WIDTH-1:0] dividend;
  logic                  div_done;
  logic [TIME_WIDTH-1:0] rem;
  logic [TIME_WIDTH-1:0] base;
  logic [TIME_WIDTH:0]   sum_nm, sum_step;
  logic [TIME_WIDTH-1:0] next_mult, step;
  logic                  acc, d_ev, i_ev;
  logic                  at_delay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_delay_q       <= '0;
      cfg_delay_en_q    <= 1'b0;
      cfg_interval_q    <= '0;
      cfg_interval_en_q <= 1'b0;
      cfg_offset_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prt_pkg::CFG_DELAY_MS:        cfg_delay_q       <= TIME_WIDTH'(cfg_wdata_i);
        prt_pkg::CFG_DELAY_ENABLE:    cfg_delay_en_q    <= cfg_wdata_i[0];
        prt_pkg::CFG_INTERVAL_MS:     cfg_interval_q    <= TIME_WIDTH'(cfg_wdata_i);
        prt_pkg::CFG_INTERVAL_ENABLE: cfg_interval_en_q <= cfg_wdata_i[0];
        prt_pkg::CFG_OFFSET_MS:       cfg_offset_q      <= TIME_WIDTH'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= in_item_i.op;
      pos_q <= TIME_WIDTH'(in_item_i.position_ms);
    end
  end

  assign dividend = (op_q == prt_pkg::OP_START) ? offset_q : target_q;
  assign at_delay = dly_act_q && (target_q == delay_q);

  prt_div #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .divisor_i (iv_q),
    .done_o    (div_done),
    .rem_o     (rem)
  );

  // Next multiple of the interval strictly above the dividend, saturated.
  assign base      = dividend - rem;
  assign sum_nm    = {1'b0, base} + {1'b0, iv_q};
  assign next_mult = sum_nm[TIME_WIDTH] ? TimeMax : sum_nm[TIME_WIDTH-1:0];
  assign sum_step  = {1'b0, target_q} + {1'b0, iv_q};
  assign step      = sum_step[TIME_WIDTH] ? TimeMax : sum_step[TIME_WIDTH-1:0];

  always_comb begin
    status_o.needs_div =
      ((op_q == prt_pkg::OP_START) && int_act_q &&
       (mode_q inside {prt_pkg::MODE_ARMED, prt_pkg::MODE_PAUSED})) ||
      ((op_q == prt_pkg::OP_SAMPLE) && (mode_q == prt_pkg::MODE_RUNNING) &&
       int_act_q && at_delay && (pos_q >= target_q));
    status_o.div_done = div_done;
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

  always_comb begin
    mode_d    = mode_q;
    dly_act_d = dly_act_q;
    int_act_d = int_act_q;
    delay_d   = delay_q;
    iv_d      = iv_q;
    offset_d  = offset_q;
    target_d  = target_q;
    acc       = 1'b0;
    d_ev      = 1'b0;
    i_ev      = 1'b0;
    case (prt_pkg::op_e'(op_q))
      prt_pkg::OP_ARM: begin
        if (mode_q == prt_pkg::MODE_IDLE &&
            !(cfg_interval_en_q && cfg_interval_q == '0)) begin
          mode_d    = prt_pkg::MODE_ARMED;
          acc       = 1'b1;
          iv_d      = cfg_interval_q;
          int_act_d = cfg_interval_en_q;
          delay_d   = cfg_delay_q;
          dly_act_d = cfg_delay_en_q && (cfg_delay_q >= cfg_offset_q);
          offset_d  = cfg_offset_q;
        end
      end
      prt_pkg::OP_START: begin
        if (mode_q inside {prt_pkg::MODE_ARMED, prt_pkg::MODE_PAUSED}) begin
          acc    = 1'b1;
          mode_d = prt_pkg::MODE_RUNNING;
          if (dly_act_q && int_act_q) begin
            target_d = (delay_q < next_mult) ? delay_q : next_mult;
          end else if (dly_act_q) begin
            target_d = delay_q;
          end else if (int_act_q) begin
            target_d = next_mult;
          end else begin
            mode_d = prt_pkg::MODE_IDLE;
          end
        end
      end
      prt_pkg::OP_PAUSE: begin
        if (mode_q == prt_pkg::MODE_RUNNING) begin
          mode_d = prt_pkg::MODE_PAUSED;
          acc    = 1'b1;
        end
      end
      prt_pkg::OP_RESUME: begin
        if (mode_q == prt_pkg::MODE_PAUSED) begin
          mode_d = prt_pkg::MODE_RUNNING;
          acc    = 1'b1;
        end
      end
      prt_pkg::OP_STOP: begin
        if (mode_q != prt_pkg::MODE_IDLE) begin
          mode_d    = prt_pkg::MODE_IDLE;
          acc       = 1'b1;
          dly_act_d = 1'b0;
          int_act_d = 1'b0;
          target_d  = '0;
        end
      end
      prt_pkg::OP_SAMPLE: begin
        if (mode_q == prt_pkg::MODE_RUNNING && (dly_act_q || int_act_q) &&
            pos_q >= target_q) begin
          if (at_delay) begin
            d_ev = 1'b1;
            i_ev = int_act_q && (iv_q != '0) && (rem == '0);
          end else begin
            i_ev = 1'b1;
          end
          if (!dly_act_q) begin
            target_d = step;
          end else if (!int_act_q) begin
            if (target_q == delay_q) begin
              dly_act_d = 1'b0;
            end else begin
              target_d = delay_q;
            end
          end else if (target_q < delay_q) begin
            target_d = (step > delay_q) ? delay_q : step;
          end else if (target_q == delay_q) begin
            target_d = next_mult;
          end else begin
            target_d = step;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.mode_now         = mode_d;
    out_d.accepted         = acc;
    out_d.delay_elapsed    = d_ev;
    out_d.interval_elapsed = i_ev;
    out_d.next_target_ms   = prt_pkg::FieldWidth'(target_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= prt_pkg::MODE_IDLE;
      dly_act_q   <= 1'b0;
      int_act_q   <= 1'b0;
      delay_q     <= '0;
      iv_q        <= '0;
      offset_q    <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        mode_q    <= mode_d;
        dly_act_q <= dly_act_d;
        int_act_q <= int_act_d;
        delay_q   <= delay_d;
        iv_q      <= iv_d;
        offset_q  <= offset_d;
        target_q  <= target_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/prt_ctrl.sv -----
// Controller: sequences accept, divide and commit for one item at a time.
`timescale 1ns / 1ps
module prt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output prt_pkg::ctrl_cmd_t  cmd_o,
  input  prt_pkg::dp_status_t status_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.load_in   = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.commit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.needs_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !status_i.out_busy) else $error("commit into a full result register");
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == ST_DIV)) else $error("divide start without wait");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !status_i.div_done) |=> (state_q == ST_DIV))
    else $error("left divide wait early");

endmodule

// ----- hw/rtl/progress_report_timer_unit.sv -----
// Top level of the progress report timer: controller, datapath and divider.
// Sequencing: arm, pause, resume, stop and samples commit from the execute state; an
//   accepted start or a delay-mark sample with active interval runs the remainder divider
//   first and commits from the finish state once it is done. One item at a time: the next
//   item is taken only after the commit returns to idle. Result stalls delay the commit.
// Reset: asynchronous, clears configuration and timer state to idle; no clearing pass.
`timescale 1ns / 1ps
module progress_report_timer_unit #(
  parameter int TIME_WIDTH = prt_pkg::TimeWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [prt_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [prt_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  prt_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output prt_pkg::out_item_t               out_item_o
);

  prt_pkg::ctrl_cmd_t  cmd;
  prt_pkg::dp_status_t status;

  prt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  prt_datapath #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule
